@@ hw/rtl/tfpr_pkg.sv @@
// shared constants, codes and command/status types of the trailer framed packet receiver
`timescale 1ns / 1ps
`default_nettype none

package tfpr_pkg;

   // frame store geometry
   localparam int BufSize  = 64;
   localparam int IdCount  = 16;
   localparam int HdrBytes = 8;
   localparam int AddrW    = $clog2(BufSize);
   localparam int PosW     = $clog2(BufSize + 1);
   localparam int CmpW     = (PosW > 9) ? PosW + 1 : 10;

   // trailer bytes, oldest first
   localparam logic [7:0] Trail0 = 8'h68;
   localparam logic [7:0] Trail1 = 8'h69;
   localparam logic [7:0] Trail2 = 8'h70;

   // result kinds
   localparam logic KindHeader  = 1'b0;
   localparam logic KindPayload = 1'b1;

   // status codes
   localparam logic [1:0] StatusOk       = 2'd0;
   localparam logic [1:0] StatusChecksum = 2'd1;
   localparam logic [1:0] StatusBadId    = 2'd2;
   localparam logic [1:0] StatusOverflow = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic wr;
      logic scan_start;
      logic scan_issue;
      logic latch_status;
      logic pay_start;
      logic pay_issue;
      logic show_pay;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic trailer;
      logic scan_more;
      logic hdr_last;
      logic pay_last;
   } sts_type;

endpackage

`default_nettype wire

@@ hw/rtl/tfpr_datapath.sv @@
// datapath: frame store, trailer match, checksum sums, header fields and result mux
`timescale 1ns / 1ps
`default_nettype none

module tfpr_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tfpr_pkg::cmd_type cmd,
   output tfpr_pkg::sts_type     sts,
   input  wire logic [7:0]       req_rx_byte,
   output logic                  rsp_kind,
   output logic [7:0]            rsp_packet_id,
   output logic [7:0]            rsp_payload_len,
   output logic [31:0]           rsp_timestamp,
   output logic [1:0]            rsp_status,
   output logic [7:0]            rsp_data_byte,
   output logic                  rsp_last
);

   // frame store and per-entry written flags
   logic [7:0]                   store [tfpr_pkg::BufSize];
   logic [tfpr_pkg::BufSize-1:0] vld_ff;
   logic [7:0]                   mem_q_ff;
   logic                         vld_q_ff;

   // write side
   logic [tfpr_pkg::PosW-1:0]    wp_ff, wp_in, wp_eff;
   logic [7:0]                   hist0_ff, hist1_ff;
   logic [tfpr_pkg::AddrW-1:0]   wr_addr;

   // scan side
   logic [tfpr_pkg::PosW-1:0]    rd_idx_ff, rd_idx_in;
   logic [tfpr_pkg::PosW-1:0]    tag_ff;
   logic                         pend_ff, pend_in;
   logic [tfpr_pkg::AddrW-1:0]   rd_addr;
   logic                         rd_en;

   // frame fields and sums
   logic [7:0]                   id_ff, len_ff, s1_ff, s2_ff, s1_in, s2_in;
   logic [31:0]                  ts_ff;
   logic [15:0]                  chk_ff;
   logic [1:0]                   status_ff, status_in;
   logic [7:0]                   byte_rd;
   logic [tfpr_pkg::CmpW-1:0]    end_pos;
   logic                         ovf;
   logic                         accum;

   // write position wrap and advance
   always_comb begin
      wp_eff  = (wp_ff >= tfpr_pkg::PosW'(tfpr_pkg::BufSize)) ? '0 : wp_ff;
      wr_addr = wp_eff[tfpr_pkg::AddrW-1:0];
      wp_in = wp_ff;
      if (cmd.wr) begin
         wp_in = sts.trailer ? '0 : tfpr_pkg::PosW'(wp_eff + tfpr_pkg::PosW'(1));
      end
   end

   // trailer match on the incoming byte, frame end position and overflow
   always_comb begin
      sts.trailer = (wp_eff >= tfpr_pkg::PosW'(3)) && (req_rx_byte == tfpr_pkg::Trail2) &&
                    (hist1_ff == tfpr_pkg::Trail1) && (hist0_ff == tfpr_pkg::Trail0);
      end_pos = tfpr_pkg::CmpW'(tfpr_pkg::HdrBytes) + tfpr_pkg::CmpW'(len_ff);
      ovf     = end_pos > tfpr_pkg::CmpW'(tfpr_pkg::BufSize);
      sts.scan_more = (rd_idx_ff < tfpr_pkg::PosW'(tfpr_pkg::HdrBytes)) ||
                      (!ovf && (tfpr_pkg::CmpW'(rd_idx_ff) < end_pos));
      sts.pay_last  = tfpr_pkg::CmpW'(rd_idx_ff) == end_pos;
      sts.hdr_last  = (status_ff != tfpr_pkg::StatusOk) || (len_ff == 8'h00);
   end

   // read index and pending-read tracking
   always_comb begin
      rd_addr   = rd_idx_ff[tfpr_pkg::AddrW-1:0];
      rd_en     = cmd.scan_issue || cmd.pay_issue;
      rd_idx_in = rd_idx_ff;
      if (cmd.scan_start) begin
         rd_idx_in = '0;
      end else if (cmd.pay_start) begin
         rd_idx_in = tfpr_pkg::PosW'(tfpr_pkg::HdrBytes);
      end else if (rd_en) begin
         rd_idx_in = tfpr_pkg::PosW'(rd_idx_ff + tfpr_pkg::PosW'(1));
      end
      pend_in = cmd.scan_issue;
   end

   // running sums over the returned byte
   always_comb begin
      byte_rd = vld_q_ff ? mem_q_ff : 8'h00;
      accum   = (tag_ff < tfpr_pkg::PosW'(6)) ||
                (tag_ff >= tfpr_pkg::PosW'(tfpr_pkg::HdrBytes));
      s1_in   = s1_ff;
      s2_in   = s2_ff;
      if (cmd.scan_start) begin
         s1_in = 8'h00;
         s2_in = 8'h00;
      end else if (pend_ff && accum) begin
         s1_in = s1_ff + byte_rd;
         s2_in = s2_ff + s1_in;
      end
   end

   // frame status: overflow, then checksum, then id range
   always_comb begin
      if (ovf) begin
         status_in = tfpr_pkg::StatusOverflow;
      end else if (chk_ff != {s2_ff, s1_ff}) begin
         status_in = tfpr_pkg::StatusChecksum;
      end else if ({1'b0, id_ff} >= 9'(tfpr_pkg::IdCount)) begin
         status_in = tfpr_pkg::StatusBadId;
      end else begin
         status_in = tfpr_pkg::StatusOk;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff     <= '0;
         rd_idx_ff <= '0;
         pend_ff   <= 1'b0;
         vld_ff    <= '0;
         hist0_ff  <= 8'h00;
         hist1_ff  <= 8'h00;
      end else begin
         wp_ff     <= wp_in;
         rd_idx_ff <= rd_idx_in;
         pend_ff   <= pend_in;
         if (cmd.wr) begin
            vld_ff[wr_addr] <= 1'b1;
            hist0_ff        <= hist1_ff;
            hist1_ff        <= req_rx_byte;
         end
      end
   end

   // frame store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         store[wr_addr] <= req_rx_byte;
      end
      if (rd_en) begin
         mem_q_ff <= store[rd_addr];
         vld_q_ff <= vld_ff[rd_addr];
         tag_ff   <= rd_idx_ff;
      end
   end

   // header fields captured during the scan
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      if (cmd.latch_status) begin
         status_ff <= status_in;
      end
      if (pend_ff) begin
         case (tag_ff)
            tfpr_pkg::PosW'(0): id_ff          <= byte_rd;
            tfpr_pkg::PosW'(1): len_ff         <= byte_rd;
            tfpr_pkg::PosW'(2): ts_ff[7:0]     <= byte_rd;
            tfpr_pkg::PosW'(3): ts_ff[15:8]    <= byte_rd;
            tfpr_pkg::PosW'(4): ts_ff[23:16]   <= byte_rd;
            tfpr_pkg::PosW'(5): ts_ff[31:24]   <= byte_rd;
            tfpr_pkg::PosW'(6): chk_ff[7:0]    <= byte_rd;
            tfpr_pkg::PosW'(7): chk_ff[15:8]   <= byte_rd;
            default: ;
         endcase
      end
   end

   // result fields
   always_comb begin
      rsp_kind        = cmd.show_pay ? tfpr_pkg::KindPayload : tfpr_pkg::KindHeader;
      rsp_packet_id   = id_ff;
      rsp_payload_len = len_ff;
      rsp_timestamp   = ts_ff;
      rsp_status      = status_ff;
      rsp_data_byte   = cmd.show_pay ? byte_rd : 8'h00;
      rsp_last        = cmd.show_pay ? sts.pay_last : sts.hdr_last;
   end

endmodule

`default_nettype wire

@@ hw/rtl/tfpr_ctrl.sv @@
// controller: sequences byte intake, checksum scan, header and payload transfers
`timescale 1ns / 1ps
`default_nettype none

module tfpr_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire tfpr_pkg::sts_type sts,
   output tfpr_pkg::cmd_type      cmd
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StScan  = 3'd1;
   localparam logic [2:0] StCheck = 3'd2;
   localparam logic [2:0] StHdr   = 3'd3;
   localparam logic [2:0] StPRd   = 3'd4;
   localparam logic [2:0] StPay   = 3'd5;

   logic [2:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         StIdle: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.wr = 1'b1;
               if (sts.trailer) begin
                  cmd.scan_start = 1'b1;
                  state_in       = StScan;
               end
            end
         end
         StScan: begin
            if (sts.scan_more) begin
               cmd.scan_issue = 1'b1;
            end else begin
               state_in = StCheck;
            end
         end
         StCheck: begin
            cmd.latch_status = 1'b1;
            state_in         = StHdr;
         end
         StHdr: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (sts.hdr_last) begin
                  state_in = StIdle;
               end else begin
                  cmd.pay_start = 1'b1;
                  state_in      = StPRd;
               end
            end
         end
         StPRd: begin
            cmd.pay_issue = 1'b1;
            state_in      = StPay;
         end
         StPay: begin
            rsp_valid    = 1'b1;
            cmd.show_pay = 1'b1;
            if (!rsp_stall) begin
               state_in = sts.pay_last ? StIdle : StPRd;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   // no input transfer while a result is offered
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");

   // a trailer transfer starts the scan
   a_trailer_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && sts.trailer) |=> (state_ff == StScan))
      else $error("trailer did not start the scan");

   // store port used by one operation at a time
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wr, cmd.scan_issue, cmd.pay_issue, cmd.latch_status}))
      else $error("conflicting frame store commands");

endmodule

`default_nettype wire

@@ hw/rtl/trailer_framed_packet_receiver.sv @@
// top level of the trailer framed packet receiver
`timescale 1ns / 1ps
`default_nettype none

// Receives serial bytes one per transfer into a 64-byte frame store and watches for the
// trailer 0x68 0x69 0x70. A byte that does not complete a trailer leaves the receiver idle
// and ready for the next byte. A byte that completes one holds off input while the frame
// is walked through the single read port of the store: a checksum scan over the header and,
// unless the length overflows the store, the payload, then a check step that latches the
// status, then the header result and, for an accepted frame, the payload results, each read
// and then presented. The store reads as zero after reset through one written flag per
// entry; no clearing pass is needed.
module trailer_framed_packet_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [7:0]       rsp_packet_id,
   output logic [7:0]       rsp_payload_len,
   output logic [31:0]      rsp_timestamp,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_last
);

   tfpr_pkg::cmd_type cmd;
   tfpr_pkg::sts_type sts;

   // sequencing
   tfpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage and arithmetic
   tfpr_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_rx_byte     (req_rx_byte),
      .rsp_kind        (rsp_kind),
      .rsp_packet_id   (rsp_packet_id),
      .rsp_payload_len (rsp_payload_len),
      .rsp_timestamp   (rsp_timestamp),
      .rsp_status      (rsp_status),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// self-checking testbench for the trailer framed packet receiver
`timescale 1ns / 1ps

module tb;

   // one result transfer as it appears on the rsp_ ports
   typedef struct packed {
      logic        kind;
      logic [7:0]  packet_id;
      logic [7:0]  payload_len;
      logic [31:0] timestamp;
      logic [1:0]  status;
      logic [7:0]  data_byte;
      logic        last;
   } frame_result_type;

   // scoreboard: mirrors the frame store and queues the results each received byte produces
   class frame_checker;
      logic [7:0]       store [tfpr_pkg::BufSize];
      int unsigned      wr_pos;
      int unsigned      errors;
      frame_result_type pending_results [$];

      function new();
         foreach (store[i]) store[i] = 8'h00;
         wr_pos = 0;
         errors = 0;
      endfunction

      // store one accepted byte and decode a frame when it completes the trailer
      function void note_byte(logic [7:0] rx);
         int unsigned      last_pos;
         int unsigned      len;
         int unsigned      i;
         logic [7:0]       s1;
         logic [7:0]       s2;
         logic [1:0]       status;
         frame_result_type hdr;
         frame_result_type pay;
         if (wr_pos >= tfpr_pkg::BufSize) wr_pos = 0;
         store[wr_pos] = rx;
         last_pos = wr_pos;
         wr_pos++;
         if (last_pos < 3 || store[last_pos] != tfpr_pkg::Trail2 ||
             store[last_pos - 1] != tfpr_pkg::Trail1 ||
             store[last_pos - 2] != tfpr_pkg::Trail0) return;
         wr_pos = 0;
         len = 32'(store[1]);

         // status: overflow, then checksum, then id range
         if (tfpr_pkg::HdrBytes + len > tfpr_pkg::BufSize) begin
            status = tfpr_pkg::StatusOverflow;
         end else begin
            s1 = 8'h00;
            s2 = 8'h00;
            for (i = 0; i < 6; i++) begin
               s1 = s1 + store[i];
               s2 = s2 + s1;
            end
            for (i = 0; i < len; i++) begin
               s1 = s1 + store[tfpr_pkg::HdrBytes + i];
               s2 = s2 + s1;
            end
            if ({store[7], store[6]} != {s2, s1}) status = tfpr_pkg::StatusChecksum;
            else if (store[0] >= tfpr_pkg::IdCount) status = tfpr_pkg::StatusBadId;
            else status = tfpr_pkg::StatusOk;
         end

         // header first, then the payload bytes of an accepted frame
         hdr.kind        = tfpr_pkg::KindHeader;
         hdr.packet_id   = store[0];
         hdr.payload_len = store[1];
         hdr.timestamp   = {store[5], store[4], store[3], store[2]};
         hdr.status      = status;
         hdr.data_byte   = 8'h00;
         hdr.last        = (status != tfpr_pkg::StatusOk) || (len == 0);
         pending_results.push_back(hdr);
         if (hdr.last) return;
         pay = hdr;
         pay.kind = tfpr_pkg::KindPayload;
         for (i = 0; i < len; i++) begin
            pay.data_byte = store[tfpr_pkg::HdrBytes + i];
            pay.last      = (i + 1 == len);
            pending_results.push_back(pay);
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      // compare one accepted result against the oldest expectation
      function void check_result(frame_result_type got);
         frame_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result with none expected, actual kind %0d id %0h data %0h",
                     $time, got.kind, got.packet_id, got.data_byte);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("kind", 32'(want.kind), 32'(got.kind));
         compare_field("packet_id", 32'(want.packet_id), 32'(got.packet_id));
         compare_field("payload_len", 32'(want.payload_len), 32'(got.payload_len));
         compare_field("timestamp", want.timestamp, got.timestamp);
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
         compare_field("last", 32'(want.last), 32'(got.last));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_kind;
   logic [7:0]  rsp_packet_id;
   logic [7:0]  rsp_payload_len;
   logic [31:0] rsp_timestamp;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_data_byte;
   logic        rsp_last;

   int unsigned  req_idle_pct;
   int unsigned  rsp_stall_pct;
   frame_checker sb;
   logic [7:0]   frame_q [$];

   trailer_framed_packet_receiver i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_packet_id   (rsp_packet_id),
      .rsp_payload_len (rsp_payload_len),
      .rsp_timestamp   (rsp_timestamp),
      .rsp_status      (rsp_status),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // random result-side stalls
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(frame_result_type'({rsp_kind, rsp_packet_id, rsp_payload_len,
                                             rsp_timestamp, rsp_status, rsp_data_byte,
                                             rsp_last}));
   end

   // one byte transfer, with random sender gaps ahead of it
   task automatic send_byte(input logic [7:0] rx);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(rx);
   endtask

   task automatic send_frame(input int unsigned count);
      int unsigned n;
      for (n = 0; n < count; n++) send_byte(frame_q[n]);
   endtask

   // bring the write index back to zero so the next frame lines up with the store
   task automatic resync();
      while (sb.wr_pos % tfpr_pkg::BufSize != 0) begin
         if (sb.wr_pos <= tfpr_pkg::BufSize - 3) begin
            frame_q = '{tfpr_pkg::Trail0, tfpr_pkg::Trail1, tfpr_pkg::Trail2};
            send_frame(3);
         end else begin
            send_byte(8'h00);
         end
      end
   endtask

   // lay out a frame over the current store image; the checksum covers whatever the
   // store will hold in the payload range, trailer and stale bytes included
   function automatic void build_frame(input logic [7:0] id, input logic [7:0] len,
                                       input logic [31:0] stamp, input int unsigned body_len,
                                       input bit bad_sum);
      logic [7:0]  image [tfpr_pkg::BufSize];
      logic [7:0]  s1;
      logic [7:0]  s2;
      int unsigned n;
      image = sb.store;
      image[0] = id;
      image[1] = len;
      image[2] = stamp[7:0];
      image[3] = stamp[15:8];
      image[4] = stamp[23:16];
      image[5] = stamp[31:24];
      for (n = 0; n < body_len; n++) image[tfpr_pkg::HdrBytes + n] = 8'($urandom);
      image[tfpr_pkg::HdrBytes + body_len]     = tfpr_pkg::Trail0;
      image[tfpr_pkg::HdrBytes + body_len + 1] = tfpr_pkg::Trail1;
      image[tfpr_pkg::HdrBytes + body_len + 2] = tfpr_pkg::Trail2;
      s1 = 8'h00;
      s2 = 8'h00;
      for (n = 0; n < 6; n++) begin
         s1 = s1 + image[n];
         s2 = s2 + s1;
      end
      if (tfpr_pkg::HdrBytes + len <= tfpr_pkg::BufSize) begin
         for (n = 0; n < len; n++) begin
            s1 = s1 + image[tfpr_pkg::HdrBytes + n];
            s2 = s2 + s1;
         end
      end
      image[6] = bad_sum ? s1 ^ 8'($urandom_range(1, 255)) : s1;
      image[7] = s2;
      frame_q = {};
      for (n = 0; n < tfpr_pkg::HdrBytes + body_len + 3; n++) frame_q.push_back(image[n]);
   endfunction

   initial begin
      int unsigned phase;
      int unsigned phase_bytes;
      int unsigned pick;
      int unsigned body;
      int unsigned shape;
      int unsigned n;
      logic [7:0]  id;
      logic [7:0]  len;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_rx_byte   = 8'h00;
      rsp_stall     = 1'b0;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      sb            = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // short frame right after reset, length 255 overflows the store
      frame_q = '{8'hFF, 8'hFF, tfpr_pkg::Trail0, tfpr_pkg::Trail1, tfpr_pkg::Trail2};
      send_frame(frame_q.size());
      // accepted empty frame with an all-ones timestamp
      build_frame(8'h00, 8'h00, 32'hFFFF_FFFF, 0, 1'b0);
      send_frame(frame_q.size());
      // accepted frame whose payload runs over the trailer into stale bytes
      build_frame(8'(tfpr_pkg::IdCount - 1), 8'd5, 32'h0000_0000, 0, 1'b0);
      send_frame(frame_q.size());
      // checksum mismatch
      build_frame(8'd3, 8'd2, $urandom, 2, 1'b1);
      send_frame(frame_q.size());
      // id out of range with a good checksum
      build_frame(8'hFF, 8'd1, $urandom, 1, 1'b0);
      send_frame(frame_q.size());

      // random frames and noise under four idling patterns
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 86; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 86; end
            default: begin req_idle_pct = 22; rsp_stall_pct = 22; end
         endcase
         phase_bytes = 0;
         while (phase_bytes < 28) begin
            resync();
            pick = $urandom_range(99);
            if (pick < 12) begin
               // noise, sometimes with a broken trailer
               n = $urandom_range(1, 8);
               repeat (n) send_byte(8'($urandom));
               if ($urandom_range(1) == 1) begin
                  send_byte(tfpr_pkg::Trail0);
                  send_byte(tfpr_pkg::Trail1);
               end
            end else if (pick < 15) begin
               // long run of noise that can wrap the write index
               n = $urandom_range(60, 70);
               repeat (n) send_byte(8'($urandom));
            end else begin
               body  = ($urandom_range(19) == 0) ? $urandom_range(45, 53)
                                                 : $urandom_range(0, 10);
               id    = ($urandom_range(9) == 0) ? 8'($urandom_range(16, 255))
                                                : 8'($urandom_range(0, tfpr_pkg::IdCount - 1));
               shape = $urandom_range(19);
               if (shape < 14) len = 8'(body);
               else if (shape < 16) len = 8'((body + 3 > 56) ? 56 : body + $urandom_range(1, 3));
               else if (shape < 18) len = 8'($urandom_range(57, 255));
               else len = 8'($urandom_range(0, body));
               build_frame(id, len, $urandom, body, $urandom_range(9) == 0);
               // now and then a frame cut short before its trailer completes
               if ($urandom_range(19) == 0) send_frame(frame_q.size() - $urandom_range(1, 3));
               else send_frame(frame_q.size());
               phase_bytes += frame_q.size();
            end
         end
      end
      req_valid <= 1'b0;

      // drain the outstanding results
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
